### design/ovrs_pkg.sv
package ovrs_pkg;

   localparam int MASS_W  = 16;
   localparam int GRADE_W = 16;
   localparam int PRICE_W = 14;
   localparam int VALUE_W = 30;
   localparam int FRAC_W  = 15;

   localparam logic [PRICE_W-1:0] PRICE_RESET = 14'd8500;

   typedef struct packed {
      logic [MASS_W-1:0]  mass;
      logic [GRADE_W-1:0] grade;
      logic [VALUE_W-1:0] value;
   } ovrs_rec_type;

   typedef struct packed {
      logic [MASS_W-1:0]  mass;
      logic [GRADE_W-1:0] grade;
      logic               last_item;
   } ovrs_req_type;

   typedef struct packed {
      logic [MASS_W-1:0]  out_mass;
      logic [GRADE_W-1:0] out_grade;
      logic [VALUE_W-1:0] out_value;
      logic               overflow;
      logic               last_result;
   } ovrs_rsp_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price_per_kg;
   } ovrs_csr_type;

   typedef struct packed {
      logic               start;
      logic [MASS_W-1:0]  mass;
      logic [GRADE_W-1:0] grade;
      logic [PRICE_W-1:0] price;
   } ovrs_mult_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] value;
   } ovrs_mult_rsp_type;

endpackage

### design/ovrs_chan_if.sv
interface ovrs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### design/ovrs_value_unit.sv
module ovrs_value_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  ovrs_pkg::ovrs_mult_req_type mult_req,
   output ovrs_pkg::ovrs_mult_rsp_type mult_rsp
);
   import ovrs_pkg::*;

   localparam int PROD1_W = MASS_W + GRADE_W;
   localparam int PROD2_W = PROD1_W + PRICE_W;

   logic [PROD1_W-1:0] prod1_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [PROD2_W-1:0] prod2_ff;
   logic [1:0]         stage_ff;
   logic [1:0]         stage_in;

   assign stage_in = {stage_ff[0], mult_req.start};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= PROD1_W'(mult_req.mass) * PROD1_W'(mult_req.grade);
      price_ff <= mult_req.price;
      prod2_ff <= PROD2_W'(prod1_ff) * PROD2_W'(price_ff);
   end

   // top bit of the shifted product set means it no longer fits: saturate
   assign mult_rsp.done  = stage_ff[1];
   assign mult_rsp.value = prod2_ff[PROD2_W-1] ? {VALUE_W{1'b1}}
                                               : prod2_ff[FRAC_W +: VALUE_W];
endmodule

### design/ovrs_record_ram.sv
module ovrs_record_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  ovrs_pkg::ovrs_rec_type wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output ovrs_pkg::ovrs_rec_type rd_data
);
   import ovrs_pkg::*;

   ovrs_rec_type mem [DEPTH];
   ovrs_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### design/ore_value_record_sorter.sv
// Ore value record sorter. Each request beat carries one record (mass, grade
// as unsigned Q1.15); its value is (mass * grade * price_per_kg) >> 15,
// saturated to 30 bits, and the record is inserted into a sorted store held in
// a single-port-write, registered-read RAM of DEPTH entries. Insertion walks
// down from the top of the store, one read-compare-write step per record
// that must move. Requests are taken only while the block is idle. A record
// that arrives with the store full is dropped and sets the overflow flag. On
// a beat with last_item set the whole store is played out highest value
// first (later arrivals first among equal values), each response held until
// rsp ready takes it; the run then clears the store and the flag.
// price_per_kg may be written at any time the block is idle and resets to
// 8500. No clearing pass after reset.
module ore_value_record_sorter #(
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic reset,
   ovrs_chan_if.sink   req_chan,
   ovrs_chan_if.source rsp_chan,
   ovrs_chan_if.sink   csr_chan
);
   import ovrs_pkg::*;

   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_MULT      = 7'b0000010,
      ST_PROBE     = 7'b0000100,
      ST_COMPARE   = 7'b0001000,
      ST_EMIT_RD   = 7'b0010000,
      ST_EMIT_LOAD = 7'b0100000,
      ST_EMIT_HOLD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [PRICE_W-1:0] price_ff, price_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   ovrs_rec_type       new_rec_ff, new_rec_in;
   logic               last_ff, last_in;
   ovrs_rsp_type       rsp_ff, rsp_in;

   ovrs_mult_req_type  mult_req;
   ovrs_mult_rsp_type  mult_rsp;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   ovrs_rec_type       wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   ovrs_rec_type       rd_data;

   logic req_beat, rsp_beat, csr_beat;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = (state_ff == ST_EMIT_HOLD);
   assign rsp_chan.data  = rsp_ff;

   assign req_beat = req_chan.valid & req_chan.ready;
   assign rsp_beat = rsp_chan.valid & rsp_chan.ready;
   assign csr_beat = csr_chan.valid & csr_chan.ready;

   assign price_in = csr_beat ? csr_chan.data.price_per_kg : price_ff;

   assign mult_req.start = (state_ff == ST_IDLE) && req_beat &&
                           (count_ff < COUNT_W'(DEPTH));
   assign mult_req.mass  = req_chan.data.mass;
   assign mult_req.grade = req_chan.data.grade;
   assign mult_req.price = price_ff;

   ovrs_value_unit u_value (
      .clock    (clock),
      .reset    (reset),
      .mult_req (mult_req),
      .mult_rsp (mult_rsp)
   );

   ovrs_record_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = (state_ff == ST_PROBE) ? pos_ff - ADDR_W'(1) : idx_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      new_rec_in = new_rec_ff;
      last_in    = last_ff;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = new_rec_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               new_rec_in.mass  = req_chan.data.mass;
               new_rec_in.grade = req_chan.data.grade;
               new_rec_in.value = '0;
               last_in          = req_chan.data.last_item;
               if (count_ff < COUNT_W'(DEPTH)) begin
                  state_in = ST_MULT;
               end else begin
                  // store full: drop, but a last beat still plays the store out
                  dropped_in = 1'b1;
                  idx_in     = ADDR_W'(count_ff - COUNT_W'(1));
                  if (req_chan.data.last_item) begin
                     state_in = ST_EMIT_RD;
                  end
               end
            end
         end
         ST_MULT: begin
            if (mult_rsp.done) begin
               new_rec_in.value = mult_rsp.value;
               pos_in           = ADDR_W'(count_ff);
               state_in         = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + COUNT_W'(1);
               idx_in   = ADDR_W'(count_ff);
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            wr_en = 1'b1;
            if (rd_data.value > new_rec_ff.value) begin
               wr_data  = rd_data;
               pos_in   = pos_ff - ADDR_W'(1);
               state_in = ST_PROBE;
            end else begin
               count_in = count_ff + COUNT_W'(1);
               idx_in   = ADDR_W'(count_ff);
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            rsp_in.out_mass    = rd_data.mass;
            rsp_in.out_grade   = rd_data.grade;
            rsp_in.out_value   = rd_data.value;
            rsp_in.overflow    = dropped_ff;
            rsp_in.last_result = (idx_ff == '0);
            state_in           = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_beat) begin
               if (idx_ff == '0) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - ADDR_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         price_ff   <= PRICE_RESET;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         price_ff   <= price_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      new_rec_ff <= new_rec_in;
      last_ff    <= last_in;
      rsp_ff     <= rsp_in;
   end
endmodule

### tb/sv/tb_ore_value_record_sorter.sv
`timescale 1ns / 1ps

module tb_ore_value_record_sorter;
   import ovrs_pkg::*;

   localparam int STORE_DEPTH    = 64;
   localparam int RANDOM_ITEMS   = 30;
   localparam int SETTLE_CYCLES  = 4 + 2 * STORE_DEPTH + 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_CASES        = 16;

   localparam logic [VALUE_W-1:0] VALUE_SAT = {VALUE_W{1'b1}};

   typedef struct {
      bit                 new_price;
      logic [PRICE_W-1:0] price;
      logic [MASS_W-1:0]  mass;
      logic [GRADE_W-1:0] grade;
      bit                 last;
      int                 fill;     // >0: that many random records, last flag on the final one if last is set
      bit                 typed;
      logic [VALUE_W-1:0] value;
      bit                 ovf;
   } sorter_case_type;

   logic clock;
   logic reset;

   ovrs_chan_if #(.payload_type(ovrs_req_type)) req_if ();
   ovrs_chan_if #(.payload_type(ovrs_rsp_type)) rsp_if ();
   ovrs_chan_if #(.payload_type(ovrs_csr_type)) csr_if ();

   ore_value_record_sorter #(
      .DEPTH (STORE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Predictor state: store kept in ascending value order, as the block holds it
   ovrs_rec_type       ore_store[$];
   bit                 store_dropped;
   logic [PRICE_W-1:0] price_q;
   ovrs_rsp_type       expected_beats[$];
   ovrs_req_type       prev_sample;

   bit calm;
   bit hold_armed;

   int mismatches;
   int items_sent;
   int runs_done;
   int overflow_runs;
   int beats_checked;
   int price_writes;

   sorter_case_type dir_cases [N_CASES];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [VALUE_W-1:0] ore_value_of(logic [MASS_W-1:0] m,
                                                       logic [GRADE_W-1:0] g,
                                                       logic [PRICE_W-1:0] p);
      logic [63:0] prod;
      prod = (64'(m) * 64'(g) * 64'(p)) >> FRAC_W;
      if (prod > 64'(VALUE_SAT)) prod = 64'(VALUE_SAT);
      return prod[VALUE_W-1:0];
   endfunction

   function automatic void take_record(ovrs_req_type r, bit use_typed, ovrs_rsp_type typed);
      ovrs_rec_type rec;
      ovrs_rsp_type beat;
      int pos;
      if (ore_store.size() < STORE_DEPTH) begin
         rec.mass  = r.mass;
         rec.grade = r.grade;
         rec.value = ore_value_of(r.mass, r.grade, price_q);
         pos = ore_store.size();
         // equal values stay in arrival order, so the newcomer goes after them
         while (pos > 0 && ore_store[pos-1].value > rec.value) pos--;
         ore_store.insert(pos, rec);
      end else begin
         store_dropped = 1'b1;
      end
      if (!r.last_item) return;
      runs_done++;
      if (store_dropped) overflow_runs++;
      if (use_typed) begin
         expected_beats.push_back(typed);
      end else begin
         for (int k = ore_store.size() - 1; k >= 0; k--) begin
            beat.out_mass    = ore_store[k].mass;
            beat.out_grade   = ore_store[k].grade;
            beat.out_value   = ore_store[k].value;
            beat.overflow    = store_dropped;
            beat.last_result = (k == 0);
            expected_beats.push_back(beat);
         end
      end
      ore_store.delete();
      store_dropped = 1'b0;
   endfunction

   function automatic ovrs_req_type ore_sample();
      ovrs_req_type s;
      s.last_item = 1'b0;
      s.mass      = 16'($urandom_range(0, 65535));
      s.grade     = 16'($urandom_range(0, 32768));
      case ($urandom_range(0, 9))
         0: s.mass = $urandom_range(0, 1) ? '1 : '0;
         1: s.grade = 16'($urandom_range(32769, 65535));
         2, 3: begin
            // swapped factors give an equal value with a distinct record
            if (prev_sample.mass <= 16'd32768) begin
               s.mass  = prev_sample.grade;
               s.grade = prev_sample.mass;
            end
         end
         default: ;
      endcase
      prev_sample = s;
      return s;
   endfunction

   task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
      if (mismatches < 40)
         $display("MISMATCH beat %0d %s: got %0d, want %0d", beats_checked, field, got, want);
      mismatches++;
   endtask

   task automatic send_item(ovrs_req_type item, bit use_typed, ovrs_rsp_type typed);
      while (!calm && $urandom_range(0, 99) < 38) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      take_record(item, use_typed, typed);
      items_sent++;
      @(negedge clock);
   endtask

   // Sender pause: nothing offered until every result is back and the block has gone quiet
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_price(logic [PRICE_W-1:0] p);
      csr_if.valid <= 1'b1;
      csr_if.data  <= '{price_per_kg: p};
      do @(posedge clock); while (!csr_if.ready);
      price_q = p;
      price_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Result side: random back-pressure plus one long hold-off when armed
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= calm || ($urandom_range(0, 99) >= 38);
      end
   end

   always @(posedge clock) begin
      ovrs_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            flag_mismatch("unexpected beat, value", 64'(rsp_if.data.out_value), 64'd0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_if.data.out_mass !== want.out_mass)
               flag_mismatch("out_mass", 64'(rsp_if.data.out_mass), 64'(want.out_mass));
            if (rsp_if.data.out_grade !== want.out_grade)
               flag_mismatch("out_grade", 64'(rsp_if.data.out_grade), 64'(want.out_grade));
            if (rsp_if.data.out_value !== want.out_value)
               flag_mismatch("out_value", 64'(rsp_if.data.out_value), 64'(want.out_value));
            if (rsp_if.data.overflow !== want.overflow)
               flag_mismatch("overflow", 64'(rsp_if.data.overflow), 64'(want.overflow));
            if (rsp_if.data.last_result !== want.last_result)
               flag_mismatch("last_result", 64'(rsp_if.data.last_result),
                             64'(want.last_result));
         end
         beats_checked++;
      end
   end

   initial begin
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_beats.size());
      $display("ore_value_record_sorter verification failed");
      $finish;
   end

   initial begin
      ovrs_req_type item;
      ovrs_rsp_type typed;
      int run_len;
      int run_no;
      int random_items;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      calm         = 1'b0;
      hold_armed   = 1'b0;
      price_q      = PRICE_RESET;
      store_dropped = 1'b0;
      prev_sample  = '0;

      // price set, price, mass, grade, last, fill, typed, value, overflow
      dir_cases = '{
         '{0, 0,     65535, 32768, 1, 0,  1, 30'd557047500, 0},  // reset price, grade one
         '{0, 0,     0,     32768, 1, 0,  1, 30'd0,         0},
         '{0, 0,     65535, 0,     1, 0,  1, 30'd0,         0},
         '{0, 0,     65535, 65535, 1, 0,  1, VALUE_SAT,     0},  // saturates
         '{0, 0,     1000,  40000, 1, 0,  0, 30'd0,         0},  // grade above one
         '{1, 0,     65535, 65535, 1, 0,  1, 30'd0,         0},
         '{1, 16383, 65535, 65535, 1, 0,  1, VALUE_SAT,     0},
         '{1, 1,     32768, 32768, 1, 0,  1, 30'd32768,     0},
         '{1, 8500,  100,   16384, 0, 0,  0, 30'd0,         0},  // three equal values
         '{0, 0,     200,   8192,  0, 0,  0, 30'd0,         0},
         '{0, 0,     50,    32768, 0, 0,  0, 30'd0,         0},
         '{0, 0,     1,     1,     0, 0,  0, 30'd0,         0},
         '{0, 0,     40000, 30000, 1, 0,  0, 30'd0,         0},
         '{1, 4321,  0,     0,     1, 66, 0, 30'd0,         0},  // store full, last one dropped
         '{1, 8500,  2,     16384, 1, 0,  1, 30'd8500,      0},  // drop flag cleared
         '{0, 0,     21845, 43690, 1, 0,  0, 30'd0,         0}
      };

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_cases[i]) begin
         if (dir_cases[i].new_price) begin
            settle_block();
            set_price(dir_cases[i].price);
         end
         if (dir_cases[i].fill > 0) begin
            for (int n = 0; n < dir_cases[i].fill; n++) begin
               item = ore_sample();
               item.last_item = dir_cases[i].last && (n == dir_cases[i].fill - 1);
               send_item(item, 1'b0, '0);
            end
         end else begin
            item  = '{mass: dir_cases[i].mass, grade: dir_cases[i].grade,
                      last_item: dir_cases[i].last};
            typed = '{out_mass: dir_cases[i].mass, out_grade: dir_cases[i].grade,
                      out_value: dir_cases[i].value, overflow: dir_cases[i].ovf,
                      last_result: 1'b1};
            send_item(item, dir_cases[i].typed, typed);
         end
      end

      run_no       = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS || run_no < 10) begin
         run_len = $urandom_range(1, 4);
         if (run_no % 5 == 2) begin
            settle_block();
            case ($urandom_range(0, 3))
               0: set_price('0);
               1: set_price(PRICE_RESET);
               default: set_price(PRICE_W'($urandom_range(0, 8500)));
            endcase
         end
         // short run, then the next one is offered while results are held back
         if (run_no == 3) begin
            run_len    = 4;
            hold_armed = 1'b1;
         end
         calm = (run_no >= 6 && run_no < 10);
         for (int k = 0; k < run_len; k++) begin
            item = ore_sample();
            item.last_item = (k == run_len - 1);
            send_item(item, 1'b0, '0);
         end
         random_items += run_len;
         run_no++;
      end
      calm = 1'b0;

      settle_block();
      $display("covered %0d records in %0d sort runs, %0d result beats, %0d price writes",
               items_sent, runs_done, beats_checked, price_writes);
      $display("%0d runs dropped records; long result hold-off and input stall exercised",
               overflow_runs);
      if (mismatches == 0) begin
         $display("ore_value_record_sorter verification clean");
      end else begin
         $display("ore_value_record_sorter verification failed");
      end
      $finish;
   end

endmodule
